@@ sv/tpu_pkg.sv @@
package tpu_pkg;

    localparam int CHAN_W = 6;
    localparam int ROWS_W = 9;

    // note kinds
    localparam logic [2:0] NK_ABSENT  = 3'd0;
    localparam logic [2:0] NK_PITCHED = 3'd1;
    localparam logic [2:0] NK_EMPTY   = 3'd2;
    localparam logic [2:0] NK_OFF     = 3'd3;
    localparam logic [2:0] NK_CUT     = 3'd4;

    // special note bytes
    localparam logic [7:0] NOTE_EMPTY = 8'd253;
    localparam logic [7:0] NOTE_OFF   = 8'd254;
    localparam logic [7:0] NOTE_CUT   = 8'd255;

    localparam logic [7:0] VOL_MAX = 8'd64;

    // effect codes
    localparam logic [3:0] EC_ABSENT   = 4'd0;
    localparam logic [3:0] EC_UNKNOWN  = 4'd1;
    localparam logic [3:0] EC_SPEED    = 4'd2;
    localparam logic [3:0] EC_JUMP     = 4'd3;
    localparam logic [3:0] EC_BREAK    = 4'd4;
    localparam logic [3:0] EC_VOLSLIDE = 4'd5;
    localparam logic [3:0] EC_DOWN     = 4'd6;
    localparam logic [3:0] EC_UP       = 4'd7;
    localparam logic [3:0] EC_PORTA    = 4'd8;
    localparam logic [3:0] EC_VIBRATO  = 4'd9;
    localparam logic [3:0] EC_ARPEGGIO = 4'd10;
    localparam logic [3:0] EC_VIBVOL   = 4'd11;
    localparam logic [3:0] EC_PORTAVOL = 4'd12;
    localparam logic [3:0] EC_OFFSET   = 4'd13;
    localparam logic [3:0] EC_TEMPO    = 4'd14;

    // command letters, A = 1
    localparam logic [7:0] CMD_A = 8'd1;
    localparam logic [7:0] CMD_B = 8'd2;
    localparam logic [7:0] CMD_C = 8'd3;
    localparam logic [7:0] CMD_D = 8'd4;
    localparam logic [7:0] CMD_E = 8'd5;
    localparam logic [7:0] CMD_F = 8'd6;
    localparam logic [7:0] CMD_G = 8'd7;
    localparam logic [7:0] CMD_H = 8'd8;
    localparam logic [7:0] CMD_J = 8'd10;
    localparam logic [7:0] CMD_K = 8'd11;
    localparam logic [7:0] CMD_L = 8'd12;
    localparam logic [7:0] CMD_O = 8'd15;
    localparam logic [7:0] CMD_T = 8'd20;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       pattern_start;
    } t_in_item;

    typedef struct packed {
        logic [2:0] note_kind;
        logic [3:0] note_semitone;
        logic [4:0] note_octave;
        logic       inst_present;
        logic [7:0] instrument;
        logic       volume_present;
        logic [6:0] volume;
        logic [3:0] effect_code;
        logic [7:0] effect_info;
    } t_entry;

    typedef struct packed {
        logic [CHAN_W-1:0] channel;
        logic [7:0]        row;
        logic [2:0]        note_kind;
        logic [3:0]        note_semitone;
        logic [4:0]        note_octave;
        logic              inst_present;
        logic [7:0]        instrument;
        logic              volume_present;
        logic [6:0]        volume;
        logic [3:0]        effect_code;
        logic [7:0]        effect_info;
    } t_out_item;

    typedef struct packed {
        logic              rd_en;
        logic [CHAN_W-1:0] rd_chan;
        logic              we;
        logic [CHAN_W-1:0] wr_chan;
        logic [7:0]        wr_mask;
        t_entry            wr_entry;
        logic              clear;
    } t_mem_req;

    typedef struct packed {
        logic [7:0] mask;
        t_entry     entry;
    } t_mem_rsp;

    function automatic logic [3:0] cmd_code(logic [7:0] b);
        logic [3:0] c;
        case (b)
            CMD_A:   c = EC_SPEED;
            CMD_B:   c = EC_JUMP;
            CMD_C:   c = EC_BREAK;
            CMD_D:   c = EC_VOLSLIDE;
            CMD_E:   c = EC_DOWN;
            CMD_F:   c = EC_UP;
            CMD_G:   c = EC_PORTA;
            CMD_H:   c = EC_VIBRATO;
            CMD_J:   c = EC_ARPEGGIO;
            CMD_K:   c = EC_VIBVOL;
            CMD_L:   c = EC_PORTAVOL;
            CMD_O:   c = EC_OFFSET;
            CMD_T:   c = EC_TEMPO;
            default: c = EC_UNKNOWN;
        endcase
        return c;
    endfunction

    // b / 12 via reciprocal 171 / 2048, exact for 8-bit b; remainder by back-multiply
    function automatic logic [8:0] note_split(logic [7:0] b);
        logic [15:0] prod;
        logic [4:0]  q;
        logic [7:0]  r;
        prod = 16'(b) * 16'd171;
        q    = prod[15:11];
        r    = b - 8'(8'(q) * 8'd12);
        return {q, r[3:0]};
    endfunction

    function automatic t_out_item make_item(logic [CHAN_W-1:0] chan, logic [7:0] row,
                                            t_entry e);
        t_out_item it;
        it.channel        = chan;
        it.row            = row;
        it.note_kind      = e.note_kind;
        it.note_semitone  = e.note_semitone;
        it.note_octave    = e.note_octave;
        it.inst_present   = e.inst_present;
        it.instrument     = e.instrument;
        it.volume_present = e.volume_present;
        it.volume         = e.volume;
        it.effect_code    = e.effect_code;
        it.effect_info    = e.effect_info;
        return it;
    endfunction

endpackage

@@ sv/tpu_chmem.sv @@
module tpu_chmem #(
    parameter int CHANNELS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tpu_pkg::t_mem_req i_req,
    output tpu_pkg::t_mem_rsp o_rsp
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [tpu_pkg::CHAN_W:0] NCH = (tpu_pkg::CHAN_W + 1)'(CHANNELS);

    logic [7:0]      r_mask_mem  [CHANNELS];
    tpu_pkg::t_entry r_entry_mem [CHANNELS];
    logic [CHANNELS-1:0] r_valid;

    logic [7:0]      r_rd_mask;
    tpu_pkg::t_entry r_rd_entry;
    logic            r_rd_ok;

    logic          rd_in, wr_in, byp;
    logic [AW-1:0] ra, wa;

    assign rd_in = {1'b0, i_req.rd_chan} < NCH;
    assign wr_in = {1'b0, i_req.wr_chan} < NCH;
    assign ra    = i_req.rd_chan[AW-1:0];
    assign wa    = i_req.wr_chan[AW-1:0];
    // write-first: an entry written in the same cycle it is read
    assign byp   = i_req.we && wr_in && (i_req.wr_chan == i_req.rd_chan);

    always_ff @(posedge i_clk) begin
        if (i_req.we && wr_in) begin
            r_mask_mem[wa]  <= i_req.wr_mask;
            r_entry_mem[wa] <= i_req.wr_entry;
        end
        if (i_req.rd_en) begin
            if (byp) begin
                r_rd_mask  <= i_req.wr_mask;
                r_rd_entry <= i_req.wr_entry;
            end else begin
                r_rd_mask  <= r_mask_mem[ra];
                r_rd_entry <= r_entry_mem[ra];
            end
        end
    end

    // per-channel valid bits stand in for clearing the arrays
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_req.clear) begin
                r_valid <= '0;
            end else if (i_req.we && wr_in) begin
                r_valid[wa] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_ok <= !i_req.clear && rd_in && (r_valid[ra] || byp);
            end
        end
    end

    assign o_rsp.mask  = r_rd_ok ? r_rd_mask : 8'd0;
    assign o_rsp.entry = r_rd_ok ? r_rd_entry : '0;

endmodule

@@ sv/tpu_outq.sv @@
module tpu_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tpu_pkg::t_out_item i_item,
    output logic               o_room,
    output logic               o_valid,
    input  logic               i_stall,
    output tpu_pkg::t_out_item o_item
);

    tpu_pkg::t_out_item r_slot [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       pop;

    assign pop     = (r_cnt != 2'd0) && !i_stall;
    assign o_valid = r_cnt != 2'd0;
    assign o_room  = r_cnt != 2'd2;
    assign o_item  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp <= r_wp ^ i_push;
            r_rp <= r_rp ^ pop;
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ sv/tpu_parser.sv @@
module tpu_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  tpu_pkg::t_in_item          i_in_data,
    input  logic                       i_room,
    input  logic                       i_cfg_valid,
    input  logic [tpu_pkg::ROWS_W-1:0] i_cfg_data,
    output logic                       o_emit,
    output tpu_pkg::t_out_item         o_item,
    output tpu_pkg::t_mem_req          o_req,
    input  tpu_pkg::t_mem_rsp          i_rsp
);

    typedef enum logic [2:0] {
        PH_CHAN, PH_MASK, PH_LOOKUP, PH_NOTE, PH_INST, PH_VOL, PH_COMM, PH_INFO
    } t_phase;

    t_phase                       r_phase, n_phase;
    logic [tpu_pkg::CHAN_W-1:0]   r_chan, n_chan;
    logic [7:0]                   r_mask, n_mask;
    logic [tpu_pkg::ROWS_W-1:0]   r_row, n_row;
    tpu_pkg::t_entry              r_pend, n_pend;
    logic [tpu_pkg::ROWS_W-1:0]   r_rows;

    logic            accept;
    logic [7:0]      b;
    logic [8:0]      split;
    logic [7:0]      bcd;
    tpu_pkg::t_entry fin;

    // next data phase after 'from' that the mask selects, PH_CHAN when none is left
    function automatic t_phase next_phase(t_phase from, logic [7:0] m);
        logic f_mask, f_note, f_inst, f_vol;
        f_mask = from == PH_MASK;
        f_note = f_mask || from == PH_NOTE;
        f_inst = f_note || from == PH_INST;
        f_vol  = f_inst || from == PH_VOL;
        if (f_mask && m[0]) return PH_NOTE;
        else if (f_note && m[1]) return PH_INST;
        else if (f_inst && m[2]) return PH_VOL;
        else if (f_vol && m[3]) return PH_COMM;
        else return PH_CHAN;
    endfunction

    function automatic tpu_pkg::t_entry apply_copy(tpu_pkg::t_entry p, logic [7:0] m,
                                                   tpu_pkg::t_entry last);
        tpu_pkg::t_entry e;
        e = p;
        if (m[4]) begin
            e.note_kind     = last.note_kind;
            e.note_semitone = last.note_semitone;
            e.note_octave   = last.note_octave;
        end
        if (m[5]) begin
            e.inst_present = last.inst_present;
            e.instrument   = last.instrument;
        end
        if (m[6]) begin
            e.volume_present = last.volume_present;
            e.volume         = last.volume;
        end
        if (m[7]) begin
            e.effect_code = last.effect_code;
            e.effect_info = last.effect_info;
        end
        return e;
    endfunction

    assign accept = i_in_valid && i_room;
    assign b      = i_in_data.data_byte;
    assign split  = tpu_pkg::note_split(b);
    assign bcd    = 8'({4'd0, b[7:4]} * 8'd10) + {4'd0, b[3:0]};

    always_comb begin
        n_phase = r_phase;
        n_chan  = r_chan;
        n_mask  = r_mask;
        n_row   = r_row;
        n_pend  = r_pend;
        fin     = '0;
        o_emit  = 1'b0;
        o_item  = '0;
        o_req   = '0;

        // mask lookup issued by the previous channel byte resolves first
        if (r_phase == PH_LOOKUP && i_room) begin
            n_mask  = i_rsp.mask;
            n_phase = next_phase(PH_MASK, i_rsp.mask);
            if (n_phase == PH_CHAN) begin
                fin    = apply_copy(r_pend, i_rsp.mask, i_rsp.entry);
                o_emit = 1'b1;
                o_item = tpu_pkg::make_item(r_chan, r_row[7:0], fin);
                n_pend = '0;
            end
        end

        if (accept && i_in_data.pattern_start) begin
            n_phase     = PH_CHAN;
            n_chan      = '0;
            n_mask      = '0;
            n_row       = '0;
            n_pend      = '0;
            o_req.clear = 1'b1;
        end

        if (accept) begin
            case (n_phase)
                PH_CHAN: begin
                    if (n_row < r_rows) begin
                        if (b == 8'd0) begin
                            n_row = n_row + 1'b1;
                        end else begin
                            n_chan        = tpu_pkg::CHAN_W'(b - 8'd1);
                            n_pend        = '0;
                            o_req.rd_en   = 1'b1;
                            o_req.rd_chan = tpu_pkg::CHAN_W'(b - 8'd1);
                            n_phase       = b[7] ? PH_MASK : PH_LOOKUP;
                        end
                    end
                end
                PH_MASK: begin
                    n_mask  = b;
                    n_phase = next_phase(PH_MASK, b);
                end
                PH_NOTE: begin
                    if (b == tpu_pkg::NOTE_EMPTY) begin
                        n_pend.note_kind = tpu_pkg::NK_EMPTY;
                    end else if (b == tpu_pkg::NOTE_OFF) begin
                        n_pend.note_kind = tpu_pkg::NK_OFF;
                    end else if (b == tpu_pkg::NOTE_CUT) begin
                        n_pend.note_kind = tpu_pkg::NK_CUT;
                    end else begin
                        n_pend.note_kind     = tpu_pkg::NK_PITCHED;
                        n_pend.note_octave   = split[8:4];
                        n_pend.note_semitone = split[3:0];
                    end
                    n_phase = next_phase(PH_NOTE, n_mask);
                end
                PH_INST: begin
                    n_pend.inst_present = 1'b1;
                    n_pend.instrument   = b;
                    n_phase = next_phase(PH_INST, n_mask);
                end
                PH_VOL: begin
                    if (b <= tpu_pkg::VOL_MAX) begin
                        n_pend.volume_present = 1'b1;
                        n_pend.volume         = b[6:0];
                    end
                    n_phase = next_phase(PH_VOL, n_mask);
                end
                PH_COMM: begin
                    n_pend.effect_code = tpu_pkg::cmd_code(b);
                    n_phase = PH_INFO;
                end
                PH_INFO: begin
                    n_pend.effect_info = (n_pend.effect_code == tpu_pkg::EC_BREAK) ? bcd : b;
                    n_phase = PH_CHAN;
                end
                default: n_phase = PH_CHAN;
            endcase

            // a data byte or mask byte that leaves nothing selected completes the entry
            if (n_phase == PH_CHAN && r_phase != PH_CHAN && !o_emit
                    && !i_in_data.pattern_start) begin
                fin    = apply_copy(n_pend, n_mask, i_rsp.entry);
                o_emit = 1'b1;
                o_item = tpu_pkg::make_item(n_chan, n_row[7:0], fin);
                n_pend = '0;
            end
        end

        if (o_emit) begin
            o_req.we       = 1'b1;
            o_req.wr_chan  = o_item.channel;
            o_req.wr_mask  = (r_phase == PH_LOOKUP) ? i_rsp.mask : n_mask;
            o_req.wr_entry = fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CHAN;
            r_chan  <= '0;
            r_mask  <= '0;
            r_row   <= '0;
            r_pend  <= '0;
            r_rows  <= tpu_pkg::ROWS_W'(64);
        end else begin
            r_phase <= n_phase;
            r_chan  <= n_chan;
            r_mask  <= n_mask;
            r_row   <= n_row;
            r_pend  <= n_pend;
            if (i_cfg_valid) begin
                r_rows <= i_cfg_data;
            end
        end
    end

`ifndef SYNTHESIS
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> i_room)
        else $error("entry emitted with output queue full");

    a_lookup_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LOOKUP && $past(r_phase) != PH_LOOKUP) |-> $past(o_req.rd_en))
        else $error("mask lookup without a memory read");

    a_info_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_INFO) |-> (r_pend.effect_code != tpu_pkg::EC_ABSENT))
        else $error("info phase without a command");
`endif

endmodule

@@ sv/tracker_pattern_unpacker.sv @@
// channel   dir  handshake              payload
// in        in   i_in_valid/o_in_stall  i_in_data  (data_byte, pattern_start)
// out       out  o_out_valid/i_out_stall o_out_data (decoded entry)
// cfg       in   i_cfg_valid/o_cfg_ready i_cfg_data (rows_in_pattern)
//
// One byte per cycle while the output queue has room. A completed entry is pushed into
// the registered output queue; a reused mask is read from the channel memory into
// its registered output and resolved together with the next byte, overlapping it.
// Input stalls only while the two-entry output queue is full.
// Reset and pattern_start clear the channel memories at once through valid bits.
module tracker_pattern_unpacker #(
    parameter int CHANNELS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  tpu_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output tpu_pkg::t_out_item         o_out_data,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [tpu_pkg::ROWS_W-1:0] i_cfg_data
);

    logic               room, emit;
    tpu_pkg::t_out_item item;
    tpu_pkg::t_mem_req  req;
    tpu_pkg::t_mem_rsp  rsp;

    assign o_in_stall  = !room;
    assign o_cfg_ready = 1'b1;

    tpu_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_room     (room),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_emit     (emit),
        .o_item     (item),
        .o_req      (req),
        .i_rsp      (rsp)
    );

    tpu_chmem #(
        .CHANNELS(CHANNELS)
    ) u_chmem (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req),
        .o_rsp  (rsp)
    );

    tpu_outq u_outq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (emit),
        .i_item (item),
        .o_room (room),
        .o_valid(o_out_valid),
        .i_stall(i_out_stall),
        .o_item (o_out_data)
    );

endmodule
